// ===== design/stbs_pkg.sv =====
// Package for the sorted table search block: request, status and sequencer types.
package stbs_pkg;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned INDEX_W  = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SEARCH = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ORDER     = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ADDR,
        S_CMP,
        S_DONE
    } t_state;

endpackage

// ===== design/stbs_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
interface stbs_req_if;
    logic                               valid;
    logic                               ready;
    logic [stbs_pkg::REQ_W-1:0]         req_type;
    logic signed [stbs_pkg::VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface stbs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [stbs_pkg::STATUS_W-1:0]   status;
    logic [stbs_pkg::INDEX_W-1:0]    index;

    modport source (output valid, output status, output index, input ready);
    modport sink   (input valid, input status, input index, output ready);
endinterface

// ===== design/sorted_table_binary_search.sv =====
// Sorted table of signed values with append, clear and iterative binary search.
//
//  channel  | dir | payload                       | handshake
//  ---------+-----+-------------------------------+-------------------
//  i_req    | in  | req_type[1:0], value[31:0]    | valid/ready
//  o_rsp    | out | status[2:0], index[9:0]       | valid/ready
//
// A request is taken only in the idle state, so one word is in flight at a time.
// The response word is registered: a clear or an append goes from the start state to the
// done state, and a search alternates the address and compare states for each probe, at
// most log2(DEPTH)+1 probes through the single table read port and the shared comparator.
// The next word is taken once the block is back in idle, after the response is loaded.
// Synchronous active-low reset empties the table; the table RAM itself is not
// cleared. A stalled response holds in the output register; a finished result
// waits in the done state until that register is free.
module sorted_table_binary_search #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stbs_req_if.sink    i_req,
    stbs_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (CW > stbs_pkg::INDEX_W) ? CW : stbs_pkg::INDEX_W;

    stbs_pkg::t_state r_state, n_state;

    logic [stbs_pkg::REQ_W-1:0]          r_req;
    logic signed [stbs_pkg::VALUE_W-1:0] r_key;
    logic signed [stbs_pkg::VALUE_W-1:0] r_last, n_last;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_lo, n_lo;
    logic [CW-1:0]                       r_hi, n_hi;
    logic [CW-1:0]                       r_mid, n_mid;
    logic signed [stbs_pkg::VALUE_W-1:0] r_rdata;

    stbs_pkg::t_status                   r_res_status, n_res_status;
    logic [CW-1:0]                       r_res_index, n_res_index;
    logic [XW-1:0]                       res_index_ext;

    logic                                r_out_valid, n_out_valid;
    logic [stbs_pkg::STATUS_W-1:0]       r_out_status, n_out_status;
    logic [stbs_pkg::INDEX_W-1:0]        r_out_index, n_out_index;

    logic signed [stbs_pkg::VALUE_W-1:0] mem [DEPTH];

    logic                                accept;
    logic                                wr_en;
    logic                                rd_en;
    logic                                out_free;
    logic                                append_ok;

    // Shared comparator: table probe in the compare state, last stored value otherwise.
    logic signed [stbs_pkg::VALUE_W-1:0] cmp_a;
    logic                                cmp_lt;
    logic                                cmp_eq;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign cmp_a  = (r_state == stbs_pkg::S_CMP) ? r_rdata : r_last;
    assign cmp_lt = cmp_a < r_key;
    assign cmp_eq = cmp_a == r_key;

    // An append is refused when the key is below the last value of a non-empty table.
    assign append_ok = (r_count != CW'(DEPTH)) && ((r_count == '0) || cmp_lt || cmp_eq);

    assign res_index_ext = XW'(r_res_index);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stbs_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = stbs_pkg::S_START;
                end
            end
            stbs_pkg::S_START: begin
                unique case (r_req)
                    stbs_pkg::REQ_CLEAR,
                    stbs_pkg::REQ_APPEND: n_state = stbs_pkg::S_DONE;
                    stbs_pkg::REQ_SEARCH: n_state = stbs_pkg::S_ADDR;
                    default:              n_state = stbs_pkg::S_IDLE;
                endcase
            end
            stbs_pkg::S_ADDR: begin
                n_state = (r_lo < r_hi) ? stbs_pkg::S_CMP : stbs_pkg::S_DONE;
            end
            stbs_pkg::S_CMP: begin
                n_state = cmp_eq ? stbs_pkg::S_DONE : stbs_pkg::S_ADDR;
            end
            stbs_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = stbs_pkg::S_IDLE;
                end
            end
            default: n_state = stbs_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_last       = r_last;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        i_req.ready  = 1'b0;

        unique case (r_state)
            stbs_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
            end
            stbs_pkg::S_START: begin
                n_res_index = '0;
                n_lo        = '0;
                n_hi        = r_count;
                unique case (r_req)
                    stbs_pkg::REQ_CLEAR: begin
                        n_count      = '0;
                        n_last       = '0;
                        n_res_status = stbs_pkg::ST_CLEARED;
                    end
                    stbs_pkg::REQ_APPEND: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_status = stbs_pkg::ST_FULL;
                        end else if (!append_ok) begin
                            n_res_status = stbs_pkg::ST_ORDER;
                        end else begin
                            wr_en        = 1'b1;
                            n_last       = r_key;
                            n_count      = r_count + CW'(1);
                            n_res_index  = r_count;
                            n_res_status = stbs_pkg::ST_STORED;
                        end
                    end
                    default: ;
                endcase
            end
            stbs_pkg::S_ADDR: begin
                if (r_lo < r_hi) begin
                    n_mid = r_lo + ((r_hi - CW'(1) - r_lo) >> 1);
                    rd_en = 1'b1;
                end else begin
                    n_res_status = stbs_pkg::ST_NOT_FOUND;
                    n_res_index  = '0;
                end
            end
            stbs_pkg::S_CMP: begin
                if (cmp_eq) begin
                    n_res_status = stbs_pkg::ST_FOUND;
                    n_res_index  = r_mid;
                end else if (cmp_lt) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            stbs_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = res_index_ext[stbs_pkg::INDEX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.index  = r_out_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stbs_pkg::S_IDLE;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req.req_type;
            r_key <= i_req.value;
        end
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
    end

    // Table RAM: one write port for appends, one registered read port for probes.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= r_key;
        end
        if (rd_en) begin
            r_rdata <= mem[n_mid[AW-1:0]];
        end
    end

endmodule
